// ----- rtl/radix2_fft_core_assert.svh -----
// ---------------------------------------------------------------------------
// radix2_fft_core assertion macros
// Implication checks, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef RADIX2_FFT_CORE_ASSERT_SVH
`define RADIX2_FFT_CORE_ASSERT_SVH

`ifndef SYNTH
`define R2FFT_ASSERT_IMPL(lbl, clk, rstn, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) else $error(msg);
`define R2FFT_ASSERT_NEXT(lbl, clk, rstn, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error(msg);
`else
`define R2FFT_ASSERT_IMPL(lbl, clk, rstn, a, b, msg)
`define R2FFT_ASSERT_NEXT(lbl, clk, rstn, a, b, msg)
`endif

`endif

// ----- rtl/r2fft_pkg.sv -----
// ---------------------------------------------------------------------------
// r2fft_pkg
// Shared types, constants, twiddle tables and helpers of the FFT core.
// ---------------------------------------------------------------------------
package r2fft_pkg;

  localparam int MaxPoints = 64;
  localparam int AddrW     = 6;
  localparam int CntW      = 7;
  localparam int LogW      = 3;
  localparam int SmpW      = 16;
  localparam int BinW      = 22;
  localparam int TwW       = 16;
  localparam int TwIdxW    = 5;

  typedef struct packed {
    logic [CntW-1:0] len;
    logic [LogW-1:0] log2n;
  } cmd_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
  } smp_rd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LD_RD, S_LD_WR, S_BF_RD, S_BF_M1, S_BF_M2, S_BF_AD, S_BF_WB,
    S_OUT_RD, S_OUT_LD
  } state_e;

  function automatic logic signed [TwW-1:0] tw_cos(input logic [TwIdxW-1:0] k);
    logic signed [TwW-1:0] v;
    unique case (k)
      5'd0: v = 16'sd32767;   5'd1: v = 16'sd32610;   5'd2: v = 16'sd32138;
      5'd3: v = 16'sd31357;   5'd4: v = 16'sd30274;   5'd5: v = 16'sd28899;
      5'd6: v = 16'sd27246;   5'd7: v = 16'sd25330;   5'd8: v = 16'sd23170;
      5'd9: v = 16'sd20788;   5'd10: v = 16'sd18205;  5'd11: v = 16'sd15447;
      5'd12: v = 16'sd12540;  5'd13: v = 16'sd9512;   5'd14: v = 16'sd6393;
      5'd15: v = 16'sd3212;   5'd16: v = 16'sd0;      5'd17: v = -16'sd3212;
      5'd18: v = -16'sd6393;  5'd19: v = -16'sd9512;  5'd20: v = -16'sd12540;
      5'd21: v = -16'sd15447; 5'd22: v = -16'sd18205; 5'd23: v = -16'sd20788;
      5'd24: v = -16'sd23170; 5'd25: v = -16'sd25330; 5'd26: v = -16'sd27246;
      5'd27: v = -16'sd28899; 5'd28: v = -16'sd30274; 5'd29: v = -16'sd31357;
      5'd30: v = -16'sd32138; 5'd31: v = -16'sd32610;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  // sin(k) = cos(k - 16), with +1.0 held at 32767
  function automatic logic signed [TwW-1:0] tw_sin(input logic [TwIdxW-1:0] k);
    logic signed [TwW-1:0] v;
    if (k == 5'd0) begin
      v = 16'sd0;
    end else if (k < 5'd16) begin
      v = tw_cos(5'd16 - k);
    end else begin
      v = tw_cos(k - 5'd16);
    end
    return v;
  endfunction

  function automatic logic [LogW-1:0] log2_ceil(input logic [CntW-1:0] len);
    logic [AddrW-1:0] v;
    logic [LogW-1:0]  r;
    v = AddrW'(len - 7'd1);
    r = '0;
    for (int i = 0; i < AddrW; i++) begin
      if (v[i]) r = LogW'(i + 1);
    end
    return r;
  endfunction

  function automatic logic [AddrW-1:0] bit_rev(input logic [AddrW-1:0] i,
                                               input logic [LogW-1:0] l);
    logic [AddrW-1:0] r;
    for (int b = 0; b < AddrW; b++) begin
      r[b] = i[AddrW-1-b];
    end
    return r >> (LogW'(AddrW) - l);
  endfunction

  function automatic logic signed [BinW-1:0] sat22(input logic signed [BinW+2:0] v);
    logic signed [BinW-1:0] r;
    if (v > 25'sd2097151) begin
      r = 22'sh1FFFFF;
    end else if (v < -25'sd2097152) begin
      r = 22'sh200000;
    end else begin
      r = v[BinW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/r2fft_front.sv -----
// ---------------------------------------------------------------------------
// r2fft_front
// Collects window samples into the sample store, issues one command per window.
// ---------------------------------------------------------------------------
module r2fft_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic signed [15:0]            sample_i,
  input  logic                          end_of_window_i,
  input  logic                          hold_i,
  output logic                          push_o,
  output r2fft_pkg::cmd_t               cmd_o,
  input  r2fft_pkg::smp_rd_t            smp_rd_i,
  output logic [r2fft_pkg::SmpW-1:0]    smp_data_o
);
  import r2fft_pkg::*;

  logic [SmpW-1:0] mem [MaxPoints];
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] len;
  logic            accept, room;

  assign ready_o = !hold_i;
  assign accept  = valid_i && ready_o;
  assign room    = count_q < CntW'(MaxPoints);
  assign len     = room ? count_q + 7'd1 : count_q;
  assign push_o  = accept && end_of_window_i;
  assign cmd_o   = '{len: len, log2n: log2_ceil(len)};

  always_comb begin
    count_d = count_q;
    if (accept) begin
      if (end_of_window_i) count_d = '0;
      else if (room)       count_d = count_q + 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= '0;
    else         count_q <= count_d;
  end

  always_ff @(posedge clk_i) begin
    if (accept && room) mem[count_q[AddrW-1:0]] <= sample_i;
    if (smp_rd_i.en)    smp_data_o <= mem[smp_rd_i.addr];
  end

endmodule

// ----- rtl/r2fft_cmd_fifo.sv -----
// ---------------------------------------------------------------------------
// r2fft_cmd_fifo
// Two-entry window command queue between front and back.
// ---------------------------------------------------------------------------
module r2fft_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  r2fft_pkg::cmd_t din_i,
  input  logic            pop_i,
  output r2fft_pkg::cmd_t dout_o,
  output logic            empty_o,
  output logic            full_o
);
  import r2fft_pkg::*;

  cmd_t       slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign empty_o = cnt_q == 2'd0;
  assign full_o  = cnt_q == 2'd2;
  assign dout_o  = slot_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i)  rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wp_q] <= din_i;
  end

endmodule

// ----- rtl/r2fft_back.sv -----
// ---------------------------------------------------------------------------
// r2fft_back
// Bit-reversed load, shared butterfly unit over the work store, bin output.
// ---------------------------------------------------------------------------
module r2fft_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              empty_i,
  input  r2fft_pkg::cmd_t                   cmd_i,
  output logic                              pop_o,
  output logic                              load_busy_o,
  output r2fft_pkg::smp_rd_t                smp_rd_o,
  input  logic [r2fft_pkg::SmpW-1:0]        smp_data_i,
  output logic                              bin_valid_o,
  input  logic                              bin_ready_i,
  output logic signed [r2fft_pkg::BinW-1:0] bin_real_o,
  output logic signed [r2fft_pkg::BinW-1:0] bin_imag_o,
  output logic [5:0]                        bin_index_o,
  output logic                              last_bin_o
);
  import r2fft_pkg::*;

  `include "radix2_fft_core_assert.svh"

  logic [2*BinW-1:0] mem [MaxPoints];

  state_e            state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [LogW-1:0]   stg_q, stg_d;
  logic [AddrW-2:0]  bf_q, bf_d;
  logic              pad_q, pad_d;
  logic              ovld_q, ovld_d;
  logic [CntW-1:0]   n;
  logic [CntW-1:0]   half_n;

  logic              re_a, re_b, we;
  logic [AddrW-1:0]  ra, rb, wa, top_q, bot_q;
  logic [2*BinW-1:0] wd, rd_a_q, rd_b_q;

  logic signed [TwW-1:0]     wr_q, wi_q;
  logic signed [BinW+15:0]   p1_q, p2_q, p3_q, p4_q;
  logic signed [BinW+16:0]   sr, si;
  logic signed [BinW+1:0]    tr, ti;
  logic signed [BinW-1:0]    ur, ui, br, bi;
  logic signed [BinW-1:0]    lo_re_q, lo_im_q;
  logic [AddrW-1:0]          hspan, top, bot;
  logic [TwIdxW-1:0]         twi;
  logic                      bf_cap;

  assign n      = CntW'(1) << cmd_q.log2n;
  assign half_n = n >> 1;
  assign ur = rd_a_q[2*BinW-1:BinW];
  assign ui = rd_a_q[BinW-1:0];
  assign br = rd_b_q[2*BinW-1:BinW];
  assign bi = rd_b_q[BinW-1:0];

  // butterfly addressing of stage stg_q, butterfly bf_q
  always_comb begin
    hspan = AddrW'(1) << (stg_q - 3'd1);
    top   = ((AddrW'(bf_q) >> (stg_q - 3'd1)) << stg_q) | (AddrW'(bf_q) & (hspan - 6'd1));
    bot   = top | hspan;
    twi   = TwIdxW'((AddrW'(bf_q) & (hspan - 6'd1)) << (3'd6 - stg_q));
  end

  assign sr = (BinW+17)'(p1_q) - (BinW+17)'(p2_q) + 39'sd16384;
  assign si = (BinW+17)'(p3_q) + (BinW+17)'(p4_q) + 39'sd16384;
  assign tr = sr[BinW+16:15];
  assign ti = si[BinW+16:15];

  assign load_busy_o = (state_q == S_LD_RD) || (state_q == S_LD_WR);
  assign bin_valid_o = ovld_q;

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    idx_d    = idx_q;
    stg_d    = stg_q;
    bf_d     = bf_q;
    pad_d    = pad_q;
    ovld_d   = ovld_q && !bin_ready_i;
    pop_o    = 1'b0;
    smp_rd_o = '{en: 1'b0, addr: '0};
    re_a     = 1'b0;
    re_b     = 1'b0;
    ra       = '0;
    rb       = '0;
    we       = 1'b0;
    wa       = '0;
    wd       = '0;
    bf_cap   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          cmd_d   = cmd_i;
          idx_d   = '0;
          state_d = S_LD_RD;
        end
      end
      S_LD_RD: begin
        smp_rd_o = '{en: 1'b1, addr: bit_rev(idx_q[AddrW-1:0], cmd_q.log2n)};
        pad_d    = CntW'(smp_rd_o.addr) >= cmd_q.len;
        state_d  = S_LD_WR;
      end
      S_LD_WR: begin
        we = 1'b1;
        wa = idx_q[AddrW-1:0];
        wd = pad_q ? '0 : {BinW'(signed'(smp_data_i)), BinW'(0)};
        idx_d = idx_q + 7'd1;
        if (idx_q == n - 7'd1) begin
          idx_d = '0;
          stg_d = 3'd1;
          bf_d  = '0;
          state_d = (cmd_q.log2n == '0) ? S_OUT_RD : S_BF_RD;
        end else begin
          state_d = S_LD_RD;
        end
      end
      S_BF_RD: begin
        re_a    = 1'b1;
        re_b    = 1'b1;
        ra      = top;
        rb      = bot;
        bf_cap  = 1'b1;
        state_d = S_BF_M1;
      end
      S_BF_M1: state_d = S_BF_M2;
      S_BF_M2: state_d = S_BF_AD;
      S_BF_AD: begin
        we      = 1'b1;
        wa      = top_q;
        wd      = {sat22(25'(ur) + 25'(tr)), sat22(25'(ui) + 25'(ti))};
        state_d = S_BF_WB;
      end
      S_BF_WB: begin
        we = 1'b1;
        wa = bot_q;
        wd = {lo_re_q, lo_im_q};
        bf_d = bf_q + 5'd1;
        if (CntW'(bf_q) == half_n - 7'd1) begin
          bf_d = '0;
          if (stg_q == cmd_q.log2n) begin
            idx_d   = '0;
            state_d = S_OUT_RD;
          end else begin
            stg_d   = stg_q + 3'd1;
            state_d = S_BF_RD;
          end
        end else begin
          state_d = S_BF_RD;
        end
      end
      S_OUT_RD: begin
        if (!ovld_q) begin
          re_a    = 1'b1;
          ra      = idx_q[AddrW-1:0];
          state_d = S_OUT_LD;
        end
      end
      S_OUT_LD: begin
        ovld_d = 1'b1;
        idx_d  = idx_q + 7'd1;
        state_d = (idx_q == n - 7'd1) ? S_IDLE : S_OUT_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= '0;
      idx_q   <= '0;
      stg_q   <= 3'd1;
      bf_q    <= '0;
      pad_q   <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      idx_q   <= idx_d;
      stg_q   <= stg_d;
      bf_q    <= bf_d;
      pad_q   <= pad_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we)   mem[wa] <= wd;
    if (re_a) rd_a_q <= mem[ra];
    if (re_b) rd_b_q <= mem[rb];
    if (bf_cap) begin
      top_q <= top;
      bot_q <= bot;
      wr_q  <= tw_cos(twi);
      wi_q  <= tw_sin(twi);
    end
    if (state_q == S_BF_M1) begin
      p1_q <= wr_q * br;
      p2_q <= wi_q * bi;
    end
    if (state_q == S_BF_M2) begin
      p3_q <= wr_q * bi;
      p4_q <= wi_q * br;
    end
    if (state_q == S_BF_AD) begin
      lo_re_q <= sat22(25'(ur) - 25'(tr));
      lo_im_q <= sat22(25'(ui) - 25'(ti));
    end
    if (state_q == S_OUT_LD) begin
      bin_real_o  <= ur;
      bin_imag_o  <= ui;
      bin_index_o <= idx_q[AddrW-1:0];
      last_bin_o  <= idx_q == n - 7'd1;
    end
  end

  `R2FFT_ASSERT_IMPL(a_pop_idle, clk_i, rst_ni, pop_o, state_q == S_IDLE, "pop outside idle")
  `R2FFT_ASSERT_IMPL(a_wr_range, clk_i, rst_ni, we, CntW'(wa) < n, "work write beyond n")
  `R2FFT_ASSERT_NEXT(a_out_load, clk_i, rst_ni, state_q == S_OUT_LD, bin_valid_o, "bin not shown")

endmodule

// ----- rtl/radix2_fft_core.sv -----
// ---------------------------------------------------------------------------
// radix2_fft_core
// Radix-2 DIT FFT over a zero-padded window of up to 64 real Q1.15 samples.
// ---------------------------------------------------------------------------
// channel  dir  handshake                    payload
// sample   in   sample_valid_i/sample_ready_o sample_i, end_of_window_i
// bin      out  bin_valid_o/bin_ready_i       bin_real_o, bin_imag_o,
//                                             bin_index_o, last_bin_o
//
// Samples are taken one a cycle while sample_ready_o is high. Per window of n
// points the back end loads the work store in bit-reversed order, then runs
// (n/2)*log2 n butterflies on the single butterfly unit, then emits the bins.
// Samples stall only while a window waits or is being loaded.
// Reset clears counters and control; stores need no clearing.
// ---------------------------------------------------------------------------
module radix2_fft_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              sample_valid_i,
  output logic                              sample_ready_o,
  input  logic signed [15:0]                sample_i,
  input  logic                              end_of_window_i,
  output logic                              bin_valid_o,
  input  logic                              bin_ready_i,
  output logic signed [r2fft_pkg::BinW-1:0] bin_real_o,
  output logic signed [r2fft_pkg::BinW-1:0] bin_imag_o,
  output logic [5:0]                        bin_index_o,
  output logic                              last_bin_o
);
  import r2fft_pkg::*;

  cmd_t            push_cmd, pop_cmd;
  smp_rd_t         smp_rd;
  logic [SmpW-1:0] smp_data;
  logic            push, pop, empty, full, load_busy, hold;

  assign hold = !empty || full || load_busy;

  r2fft_front u_front (
    .clk_i, .rst_ni,
    .valid_i         (sample_valid_i),
    .ready_o         (sample_ready_o),
    .sample_i,
    .end_of_window_i,
    .hold_i          (hold),
    .push_o          (push),
    .cmd_o           (push_cmd),
    .smp_rd_i        (smp_rd),
    .smp_data_o      (smp_data)
  );

  r2fft_cmd_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i  (push),
    .din_i   (push_cmd),
    .pop_i   (pop),
    .dout_o  (pop_cmd),
    .empty_o (empty),
    .full_o  (full)
  );

  r2fft_back u_back (
    .clk_i, .rst_ni,
    .empty_i     (empty),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .load_busy_o (load_busy),
    .smp_rd_o    (smp_rd),
    .smp_data_i  (smp_data),
    .bin_valid_o,
    .bin_ready_i,
    .bin_real_o,
    .bin_imag_o,
    .bin_index_o,
    .last_bin_o
  );

endmodule

// ----- tb/tb_radix2_fft_core.sv -----
// ---------------------------------------------------------------------------
// tb_radix2_fft_core
// Feeds windows of Q1.15 samples into the FFT core and checks every bin
// against a fixed-point DIT FFT computed alongside, with random gaps and
// stalls on both channels.
// ---------------------------------------------------------------------------
module tb_radix2_fft_core;
  timeunit 1ns;
  timeprecision 1ps;
  import r2fft_pkg::*;

  typedef struct {
    logic signed [BinW-1:0] re;
    logic signed [BinW-1:0] im;
    logic [5:0]             idx;
    logic                   last;
  } bin_t;

  typedef struct {
    logic signed [15:0] smp;
    logic               eow;
    bit                 has_bin0;
    logic signed [BinW-1:0] bin0_re;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic sample_valid_i = 1'b0;
  logic sample_ready_o;
  logic signed [15:0] sample_i = '0;
  logic end_of_window_i = 1'b0;
  logic bin_valid_o;
  logic bin_ready_i = 1'b0;
  logic signed [BinW-1:0] bin_real_o, bin_imag_o;
  logic [5:0] bin_index_o;
  logic last_bin_o;

  radix2_fft_core uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  int unsigned errors = 0;
  longint unsigned cycles = 0;
  bin_t expected_bins[$];
  logic signed [15:0] window_buf[64];
  int unsigned window_len = 0;
  int hold_off = 0;
  bit stall_mode = 0;
  row_t rows[$];

  int tw_c[32] = '{32767, 32610, 32138, 31357, 30274, 28899, 27246, 25330,
    23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212,
    0, -3212, -6393, -9512, -12540, -15447, -18205, -20788,
    -23170, -25330, -27246, -28899, -30274, -31357, -32138, -32610};

  function automatic longint clamp22(longint v);
    if (v > 2097151) return 2097151;
    if (v < -2097152) return -2097152;
    return v;
  endfunction

  function automatic longint rnd15(longint v);
    return (v + 16384) >>> 15;
  endfunction

  // returns number of bins queued
  function automatic int predict_window(logic signed [15:0] smp, logic eow);
    longint wre[64], wim[64];
    int n, lg, r, m, hf, ti;
    longint wr, wi, tr, tq, ur, ui;
    bin_t b;
    if (window_len < 64) begin
      window_buf[window_len] = smp;
      window_len++;
    end
    if (!eow) return 0;
    n = 1; lg = 0;
    while (n < window_len) begin n <<= 1; lg++; end
    for (int i = 0; i < n; i++) begin
      r = 0;
      for (int b = 0; b < lg; b++) r = (r << 1) | ((i >> b) & 1);
      wre[i] = (r < window_len) ? longint'(window_buf[r]) : 0;
      wim[i] = 0;
    end
    for (int s = 1; s <= lg; s++) begin
      m = 1 << s; hf = m >> 1;
      for (int j = 0; j < hf; j++) begin
        ti = (j * (64 / m)) & 31;
        wr = tw_c[ti];
        wi = (ti == 0) ? 0 : tw_c[(ti < 16) ? 16 - ti : ti - 16];
        for (int k = j; k + hf < n; k += m) begin
          tr = rnd15(wr * wre[k+hf] - wi * wim[k+hf]);
          tq = rnd15(wr * wim[k+hf] + wi * wre[k+hf]);
          ur = wre[k]; ui = wim[k];
          wre[k] = clamp22(ur + tr); wim[k] = clamp22(ui + tq);
          wre[k+hf] = clamp22(ur - tr); wim[k+hf] = clamp22(ui - tq);
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      b = '{BinW'(wre[i]), BinW'(wim[i]), 6'(i), i == n - 1};
      expected_bins = {expected_bins, b};
    end
    window_len = 0;
    return n;
  endfunction

  task automatic send_item(logic signed [15:0] smp, logic eow);
    sample_valid_i <= 1'b1;
    sample_i <= smp;
    end_of_window_i <= eow;
    do @(posedge clk_i); while (!sample_ready_o);
    void'(predict_window(smp, eow));
  endtask

  task automatic drop_valid();
    sample_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (expected_bins.size() != 0) @(posedge clk_i);
  endtask

  // bursts of len samples with random gaps
  task automatic send_window(int len, int mode);
    logic signed [15:0] v;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: v = 16'($urandom);
        1: v = 16'sh7FFF;
        2: v = -16'sh8000;
        default: v = 16'($urandom_range(0, 200)) - 16'sd100;
      endcase
      send_item(v, i == len - 1);
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) drop_valid();
    end
  endtask

  initial begin
    int lens[$];
    logic signed [BinW-1:0] r0;
    lens = '{1, 2, 3, 5, 8};
    // directed rows: bin 0 of a one-sample window equals the sample
    rows = '{
      '{16'sh7FFF, 1'b1, 1, 22'sd32767},
      '{-16'sh8000, 1'b1, 1, -22'sd32768},
      '{16'sd0, 1'b1, 1, 22'sd0},
      '{16'sh7FFF, 1'b0, 0, 0},
      '{16'sh7FFF, 1'b1, 0, 0},
      '{-16'sh8000, 1'b0, 0, 0},
      '{16'sh7FFF, 1'b0, 0, 0},
      '{16'sh5555, 1'b1, 0, 0},
      '{16'sh1234, 1'b0, 0, 0},
      '{-16'sd1, 1'b0, 0, 0},
      '{16'sh2AAA, 1'b0, 0, 0},
      '{16'sh0F0F, 1'b1, 0, 0}
    };
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      send_item(rows[i].smp, rows[i].eow);
      if (rows[i].has_bin0) begin
        r0 = expected_bins[expected_bins.size() - (expected_bins[$].idx + 1)].re;
        if (r0 !== rows[i].bin0_re) begin
          $display("%0t row %0d bin0 exp %0d got %0d", $time, i, rows[i].bin0_re, r0);
          errors++;
        end
      end
    end
    drop_valid();
    wait_drained();
    foreach (lens[i]) send_window(lens[i], i % 4);
    // 65 samples: last one dropped
    send_window(65, 0);
    drop_valid();
    wait_drained();
    // long receiver hold-off while the sender keeps offering
    hold_off = 600;
    send_window(4, 1);
    send_window(4, 2);
    send_window(2, 0);
    drop_valid();
    wait_drained();
    stall_mode = 1;
    for (int w = 0; w < 3; w++) send_window($urandom_range(1, 4), w % 4);
    stall_mode = 0;
    drop_valid();
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      bin_ready_i <= 1'b0;
    end else if (stall_mode) begin
      bin_ready_i <= $urandom_range(0, 3) != 0;
    end else begin
      bin_ready_i <= ($urandom_range(0, 15) != 0) && (cycles % 37 < 30);
    end
  end

  always @(posedge clk_i) begin
    bin_t e;
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (rst_ni && bin_valid_o && bin_ready_i) begin
      if (expected_bins.size() == 0) begin
        $display("%0t unexpected bin idx %0d", $time, bin_index_o);
        errors++;
      end else begin
        e = expected_bins.pop_front();
        if (bin_real_o !== e.re || bin_imag_o !== e.im ||
            bin_index_o !== e.idx || last_bin_o !== e.last) begin
          $display("%0t bin mismatch exp re %0d im %0d idx %0d last %0b",
                   $time, e.re, e.im, e.idx, e.last);
          $display("%0t              got re %0d im %0d idx %0d last %0b",
                   $time, bin_real_o, bin_imag_o, bin_index_o, last_bin_o);
          errors++;
        end
      end
    end
  end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/r2fft_pkg.sv
rtl/r2fft_front.sv
rtl/r2fft_cmd_fifo.sv
rtl/r2fft_back.sv
rtl/radix2_fft_core.sv
tb/tb_radix2_fft_core.sv
